/* hdl/distributed_lock_negotiator_core_defines.svh */
// Assertion helpers for the lock negotiator engine RTL.
`ifndef DISTRIBUTED_LOCK_NEGOTIATOR_CORE_DEFINES_SVH
`define DISTRIBUTED_LOCK_NEGOTIATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DLN_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DLN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/dln_pkg.sv */
package dln_pkg;

  // Width of host ids on the ports and in the tie-break compare.
  localparam int REMOTE_ID_W   = 32;
  localparam int HOST_ID_WIDTH = 32;
  localparam int ID_W = (HOST_ID_WIDTH < REMOTE_ID_W) ? HOST_ID_WIDTH : REMOTE_ID_W;
  localparam int PEER_CNT_W    = 8;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MY_HOST_ID       = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_REMOTE_HOSTS = 1'b1;

  // Event codes
  localparam logic [2:0] REQ_ACQUIRE       = 3'd0;
  localparam logic [2:0] REQ_RELEASE       = 3'd1;
  localparam logic [2:0] REQ_REPLY         = 3'd2;
  localparam logic [2:0] REQ_REMOTE_LOCK   = 3'd3;
  localparam logic [2:0] REQ_REMOTE_UNLOCK = 3'd4;
  localparam logic [2:0] REQ_HOST_DIED     = 3'd5;
  localparam logic [2:0] REQ_SETTLE        = 3'd6;

  // Status codes
  localparam logic [2:0] ST_DONE       = 3'd0;
  localparam logic [2:0] ST_GRANTED    = 3'd1;
  localparam logic [2:0] ST_WAITING    = 3'd2;
  localparam logic [2:0] ST_BUSY       = 3'd3;
  localparam logic [2:0] ST_RECOVERING = 3'd4;
  localparam logic [2:0] ST_IGNORED    = 3'd5;

  // Answers to a remote lock request
  localparam logic [1:0] RC_OK   = 2'd0;
  localparam logic [1:0] RC_PRIO = 2'd1;
  localparam logic [1:0] RC_NONE = 2'd2;
  localparam logic [1:0] RC_NA   = 2'd3;

  typedef struct packed {
    logic [2:0]             req_type;
    logic [REMOTE_ID_W-1:0] remote_host_id;
  } dln_cmd_t;

  typedef struct packed {
    logic [2:0]             status;
    logic [1:0]             reply_code;
    logic                   send_want_lock;
    logic                   send_unlock;
    logic                   reply_underflow;
    logic [2:0]             lock_state_out;
    logic [REMOTE_ID_W-1:0] holder_id_out;
  } dln_result_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] my_host_id;
    logic [PEER_CNT_W-1:0] num_remote_hosts;
  } dln_cfg_t;

endpackage

/* hdl/dln_in_stage.sv */
module dln_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  dln_pkg::dln_cmd_t cmd,
  output logic              in_valid,
  output dln_pkg::dln_cmd_t in_cmd
);
  import dln_pkg::*;

  // Capture one transaction per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= take;
    end
    if (take) begin
      in_cmd <= cmd;
    end
  end

endmodule

/* hdl/dln_engine.sv */
`include "distributed_lock_negotiator_core_defines.svh"

module dln_engine (
  input  logic                 clk,
  input  logic                 rst,
  input  dln_pkg::dln_cfg_t    cfg,
  input  logic                 in_valid,
  input  dln_pkg::dln_cmd_t    in_cmd,
  output logic                 done,
  output dln_pkg::dln_result_t result
);
  import dln_pkg::*;

  typedef enum logic [2:0] {
    LS_NONE    = 3'd0,
    LS_SETTING = 3'd1,
    LS_LOCAL   = 3'd2,
    LS_REMOTE  = 3'd3,
    LS_RECOVER = 3'd4
  } lock_state_t;

  lock_state_t           lock_state, lock_state_next;
  logic [PEER_CNT_W-1:0] pending, pending_next;
  logic [ID_W-1:0]       holder, holder_next;
  dln_result_t           result_next;

  logic [ID_W-1:0] rid;
  logic [ID_W-1:0] mine;
  logic            no_peers;
  logic            no_pending;

  assign rid        = in_cmd.remote_host_id[ID_W-1:0];
  assign mine       = cfg.my_host_id[ID_W-1:0];
  assign no_peers   = (cfg.num_remote_hosts == '0);
  assign no_pending = (pending == '0);

  always_comb begin
    lock_state_next = lock_state;
    pending_next    = pending;
    holder_next     = holder;
    result_next.status          = ST_IGNORED;
    result_next.reply_code      = RC_NA;
    result_next.send_want_lock  = 1'b0;
    result_next.send_unlock     = 1'b0;
    result_next.reply_underflow = 1'b0;
    case (in_cmd.req_type)
      REQ_ACQUIRE: begin
        if (no_peers) begin
          result_next.status = ST_GRANTED;
        end else if (lock_state == LS_RECOVER) begin
          result_next.status = ST_RECOVERING;
        end else if (lock_state == LS_SETTING) begin
          if (!no_pending) begin
            result_next.status = ST_WAITING;
          end else begin
            lock_state_next    = LS_LOCAL;
            result_next.status = ST_GRANTED;
          end
        end else if (lock_state == LS_LOCAL || lock_state == LS_REMOTE) begin
          result_next.status = ST_BUSY;
        end else begin
          lock_state_next            = LS_SETTING;
          pending_next               = cfg.num_remote_hosts;
          result_next.send_want_lock = 1'b1;
          result_next.status         = ST_WAITING;
        end
      end
      REQ_RELEASE: begin
        result_next.status = ST_DONE;
        if (!no_peers) begin
          if (lock_state == LS_LOCAL) begin
            lock_state_next = LS_NONE;
          end
          result_next.send_unlock = 1'b1;
        end
      end
      REQ_REPLY: begin
        if (no_pending) begin
          result_next.reply_underflow = 1'b1;
        end else begin
          pending_next       = pending - 1'b1;
          result_next.status = ST_DONE;
        end
      end
      REQ_REMOTE_LOCK: begin
        result_next.status = ST_DONE;
        if (lock_state == LS_SETTING && mine < rid) begin
          // Local host wins the tie-break; the peer's request counts as a reply.
          if (no_pending) begin
            result_next.reply_underflow = 1'b1;
          end else begin
            pending_next = pending - 1'b1;
          end
          result_next.reply_code = RC_PRIO;
        end else if (lock_state == LS_SETTING || lock_state == LS_NONE) begin
          result_next.reply_code = (lock_state == LS_SETTING) ? RC_NONE : RC_OK;
          lock_state_next        = LS_REMOTE;
          holder_next            = rid;
        end else if (lock_state == LS_LOCAL) begin
          result_next.status = ST_BUSY;
        end else if (lock_state == LS_REMOTE) begin
          if (holder != '0 && holder > rid) begin
            holder_next = rid;
          end
          result_next.reply_code = RC_OK;
        end else begin
          result_next.reply_code = RC_OK;
        end
      end
      REQ_REMOTE_UNLOCK: begin
        if (lock_state == LS_REMOTE && holder == rid) begin
          lock_state_next    = LS_NONE;
          holder_next        = '0;
          result_next.status = ST_DONE;
        end
      end
      REQ_HOST_DIED: begin
        if (lock_state == LS_SETTING) begin
          lock_state_next    = LS_RECOVER;
          pending_next       = '0;
          result_next.status = ST_DONE;
        end else if (lock_state == LS_REMOTE && holder == rid) begin
          lock_state_next    = LS_NONE;
          holder_next        = '0;
          result_next.status = ST_DONE;
        end
      end
      REQ_SETTLE: begin
        if (lock_state == LS_RECOVER) begin
          lock_state_next    = LS_NONE;
          result_next.status = ST_DONE;
        end
      end
      default: begin
      end
    endcase
    result_next.lock_state_out = lock_state_next;
    result_next.holder_id_out  = REMOTE_ID_W'(holder_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_state <= LS_NONE;
      pending    <= '0;
      holder     <= '0;
      done       <= 1'b0;
    end else begin
      done <= in_valid;
      if (in_valid) begin
        lock_state <= lock_state_next;
        pending    <= pending_next;
        holder     <= holder_next;
      end
    end
    if (in_valid) begin
      result <= result_next;
    end
  end

  `DLN_ASSERT_NEXT(a_result_follows, clk, rst, in_valid, done, "registered command gave no result")
  `DLN_ASSERT_NOW(a_result_has_cmd, clk, rst, done, $past(in_valid), "result without a command")
  `DLN_ASSERT_NOW(a_holder_only_remote, clk, rst, holder != '0, lock_state == LS_REMOTE, "holder id outside remote state")
  `DLN_ASSERT_NOW(a_want_sets_setting, clk, rst, done && result.send_want_lock, result.lock_state_out == 3'(LS_SETTING) && lock_state == LS_SETTING, "lock broadcast without setting state")
  `DLN_ASSERT_NOW(a_underflow_zero, clk, rst, done && result.reply_underflow, pending == '0, "reply count moved on underflow")

endmodule

/* hdl/distributed_lock_negotiator_core.sv */
// Channel | Ports                          | Handshake
// --------+--------------------------------+-----------------------------------------
// command | start, busy, cmd               | taken at an edge with start high, busy low
// result  | done, result                   | one-cycle strobe, no back-pressure
// config  | cfg_we, cfg_idx, cfg_wdata     | written at an edge with cfg_we high
//
// One event per cycle: the command register feeds a single pass of compare
// and update logic into the state and result registers, and done rises
// together with the registered result; busy is always low.
// Synchronous active-high reset clears the lock state, reply count, holder id
// and both configuration registers. The receiver cannot stall the result.
// Write configuration only while no transaction is in flight.
module distributed_lock_negotiator_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  dln_pkg::dln_cmd_t                cmd,
  output logic                             done,
  output dln_pkg::dln_result_t             result,
  input  logic                             cfg_we,
  input  logic [dln_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [dln_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import dln_pkg::*;

  dln_cfg_t cfg;
  logic     in_valid;
  dln_cmd_t in_cmd;

  // The event pass never stalls, so never hold off a command.
  assign busy = 1'b0;

  // Configuration registers: plain write port, no read-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.my_host_id       <= '0;
      cfg.num_remote_hosts <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MY_HOST_ID:       cfg.my_host_id       <= cfg_wdata;
        CFG_NUM_REMOTE_HOSTS: cfg.num_remote_hosts <= cfg_wdata[PEER_CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register the incoming transaction.
  dln_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .take     (start && !busy),
    .cmd      (cmd),
    .in_valid (in_valid),
    .in_cmd   (in_cmd)
  );

  // Advance the lock state and build the result transaction.
  dln_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .done     (done),
    .result   (result)
  );

endmodule

/* test/distributed_lock_negotiator_core_tb.sv */
module distributed_lock_negotiator_core_tb;
  import dln_pkg::*;

  // Lock state encodings as seen on lock_state_out
  localparam logic [2:0] LS_NONE    = 3'd0;
  localparam logic [2:0] LS_SETTING = 3'd1;
  localparam logic [2:0] LS_LOCAL   = 3'd2;
  localparam logic [2:0] LS_REMOTE  = 3'd3;
  localparam logic [2:0] LS_RECOVER = 3'd4;

  localparam logic [2:0] REQ_UNKNOWN = 3'd7;
  localparam int         CYCLE_LIMIT = 600000;
  localparam int         ITEMS_PER_PHASE = 140;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  dln_cmd_t              cmd;
  logic                  done;
  dln_result_t           result;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  distributed_lock_negotiator_core u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Local copy of the negotiator state and its configuration
  logic [2:0]            lock_q;
  logic [PEER_CNT_W-1:0] pend_cnt;
  logic [ID_W-1:0]       holder_q;
  logic [ID_W-1:0]       host_id_q;
  logic [PEER_CNT_W-1:0] peer_cnt_q;

  dln_result_t outcome_q[$];
  dln_result_t due_outcome;
  int          mismatch_cnt;
  int          cycle_cnt;
  bit          gaps_on;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Work out the result of one event and advance the local state.
  function automatic dln_result_t negotiate(input dln_cmd_t c);
    dln_result_t     r;
    logic [ID_W-1:0] rid;
    rid = c.remote_host_id[ID_W-1:0];
    r = '0;
    r.status = ST_IGNORED;
    r.reply_code = RC_NA;
    case (c.req_type)
      REQ_ACQUIRE: begin
        if (peer_cnt_q == '0) begin
          r.status = ST_GRANTED;
        end else if (lock_q == LS_RECOVER) begin
          r.status = ST_RECOVERING;
        end else if (lock_q == LS_SETTING) begin
          if (pend_cnt != '0) begin
            r.status = ST_WAITING;
          end else begin
            lock_q = LS_LOCAL;
            r.status = ST_GRANTED;
          end
        end else if (lock_q == LS_LOCAL || lock_q == LS_REMOTE) begin
          r.status = ST_BUSY;
        end else begin
          // Start negotiating: ask every peer and count their replies.
          lock_q = LS_SETTING;
          pend_cnt = peer_cnt_q;
          r.send_want_lock = 1'b1;
          r.status = ST_WAITING;
        end
      end
      REQ_RELEASE: begin
        r.status = ST_DONE;
        if (peer_cnt_q != '0) begin
          if (lock_q == LS_LOCAL) lock_q = LS_NONE;
          r.send_unlock = 1'b1;
        end
      end
      REQ_REPLY: begin
        if (pend_cnt == '0) begin
          r.reply_underflow = 1'b1;
        end else begin
          pend_cnt = pend_cnt - 1'b1;
          r.status = ST_DONE;
        end
      end
      REQ_REMOTE_LOCK: begin
        r.status = ST_DONE;
        if (lock_q == LS_SETTING && host_id_q < rid) begin
          // We win the tie-break; the peer's request counts as its reply.
          if (pend_cnt == '0) r.reply_underflow = 1'b1;
          else pend_cnt = pend_cnt - 1'b1;
          r.reply_code = RC_PRIO;
        end else if (lock_q == LS_SETTING || lock_q == LS_NONE) begin
          r.reply_code = (lock_q == LS_SETTING) ? RC_NONE : RC_OK;
          lock_q = LS_REMOTE;
          holder_q = rid;
        end else if (lock_q == LS_LOCAL) begin
          r.status = ST_BUSY;
        end else if (lock_q == LS_REMOTE) begin
          if (holder_q != '0 && holder_q > rid) holder_q = rid;
          r.reply_code = RC_OK;
        end else begin
          r.reply_code = RC_OK;
        end
      end
      REQ_REMOTE_UNLOCK: begin
        if (lock_q == LS_REMOTE && holder_q == rid) begin
          lock_q = LS_NONE;
          holder_q = '0;
          r.status = ST_DONE;
        end
      end
      REQ_HOST_DIED: begin
        if (lock_q == LS_SETTING) begin
          lock_q = LS_RECOVER;
          pend_cnt = '0;
          r.status = ST_DONE;
        end else if (lock_q == LS_REMOTE && holder_q == rid) begin
          lock_q = LS_NONE;
          holder_q = '0;
          r.status = ST_DONE;
        end
      end
      REQ_SETTLE: begin
        if (lock_q == LS_RECOVER) begin
          lock_q = LS_NONE;
          r.status = ST_DONE;
        end
      end
      default: ;
    endcase
    r.lock_state_out = lock_q;
    r.holder_id_out = holder_q;
    return r;
  endfunction

  // Mostly short gaps, a few long ones; none while gaps are switched off.
  function automatic int gap_len();
    int w;
    w = $urandom_range(0, 99);
    if (!gaps_on || w < 50) return 0;
    if (w < 85) return $urandom_range(1, 3);
    if (w < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Issue one transaction and record its expected result once it is taken.
  task automatic send_event(input logic [2:0] kind, input logic [REMOTE_ID_W-1:0] rid);
    int       gap;
    dln_cmd_t c;
    gap = gap_len();
    c.req_type = kind;
    c.remote_host_id = rid;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    outcome_q.push_back(negotiate(c));
  endtask

  // Drop start and hold until every expected result has come back.
  task automatic drain();
    start <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register; call only after drain().
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_MY_HOST_ID) host_id_q = data[ID_W-1:0];
    else peer_cnt_q = data[PEER_CNT_W-1:0];
  endtask

  task automatic set_config(input logic [31:0] host, input logic [7:0] peers);
    drain();
    write_reg(CFG_MY_HOST_ID, host);
    write_reg(CFG_NUM_REMOTE_HOSTS, {{(CFG_DATA_W-PEER_CNT_W){1'b0}}, peers});
  endtask

  // Peer ids clustered around the ones that matter for tie-breaks.
  function automatic logic [REMOTE_ID_W-1:0] pick_id();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return holder_q;
      3: return host_id_q;
      4: return host_id_q + 1'b1;
      5: return host_id_q - 1'b1;
      6: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  // With negotiation off, acquire and release are local and everything else
  // still follows the state machine.
  task automatic test_negotiation_off();
    send_event(REQ_ACQUIRE, '0);
    send_event(REQ_RELEASE, '1);
    send_event(REQ_REPLY, 32'h0000_0001);
    send_event(REQ_REMOTE_LOCK, 32'hFFFF_FFFF);
    send_event(REQ_ACQUIRE, 32'h1234_5678);
    send_event(REQ_REMOTE_UNLOCK, 32'hFFFF_FFFF);
    send_event(REQ_HOST_DIED, 32'h0);
    send_event(REQ_SETTLE, 32'h0);
    send_event(REQ_UNKNOWN, 32'hA5A5_5A5A);
    drain();
  endtask

  // Walk the lock states through their main events, including the corner cases.
  task automatic test_protocol_walk();
    set_config(32'h8000_0000, 8'd3);
    send_event(REQ_ACQUIRE, '0);            // broadcast, start counting replies
    send_event(REQ_ACQUIRE, '0);            // still waiting
    repeat (3) send_event(REQ_REPLY, '0);
    send_event(REQ_ACQUIRE, '0);            // granted
    send_event(REQ_REMOTE_LOCK, 32'h1);     // busy, peer must retry
    send_event(REQ_ACQUIRE, '0);            // busy
    send_event(REQ_RELEASE, '0);
    send_event(REQ_RELEASE, '0);            // not held, unlock still sent
    send_event(REQ_REMOTE_LOCK, 32'h5);
    send_event(REQ_REMOTE_LOCK, 32'h3);     // lower requester takes over
    send_event(REQ_REMOTE_LOCK, '1);
    send_event(REQ_REMOTE_UNLOCK, 32'h7);   // wrong holder
    send_event(REQ_REMOTE_UNLOCK, 32'h3);
    send_event(REQ_ACQUIRE, '0);
    send_event(REQ_REMOTE_LOCK, '1);        // we win the tie-break
    send_event(REQ_REMOTE_LOCK, 32'h1);     // peer wins during setting
    send_event(REQ_HOST_DIED, 32'h2);
    send_event(REQ_HOST_DIED, 32'h1);
    send_event(REQ_ACQUIRE, '0);
    send_event(REQ_HOST_DIED, '0);          // setting aborted, recover
    send_event(REQ_ACQUIRE, '0);
    send_event(REQ_REMOTE_LOCK, 32'h9);
    send_event(REQ_SETTLE, '0);
    send_event(REQ_SETTLE, '0);
    send_event(REQ_REPLY, '0);              // underflow
    drain();
    // Zero holder is never displaced; tie-break win with no replies left.
    set_config(32'h0000_0010, 8'd1);
    send_event(REQ_REMOTE_LOCK, '0);
    send_event(REQ_REMOTE_LOCK, '0);
    send_event(REQ_REMOTE_UNLOCK, '0);
    send_event(REQ_ACQUIRE, '0);
    send_event(REQ_REPLY, '0);
    send_event(REQ_REMOTE_LOCK, '1);        // underflow on the tie-break
    send_event(REQ_UNKNOWN, '1);
    send_event(REQ_ACQUIRE, '0);
    send_event(REQ_RELEASE, '0);
    drain();
  endtask

  // Random traffic steered toward complete negotiations, with noise.
  task automatic test_random_traffic();
    logic [31:0] hosts [6];
    logic [7:0]  peers [6];
    logic [2:0]  kind;
    int          w;
    hosts = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, $urandom, 32'h5, $urandom};
    peers = '{8'd1, 8'd255, 8'd3, 8'd0, 8'd2, 8'($urandom_range(1, 8))};
    for (int ph = 0; ph < 6; ph++) begin
      set_config(hosts[ph], peers[ph]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 59) == 0) drain();
        w = $urandom_range(0, 99);
        if (lock_q == LS_SETTING && pend_cnt != '0 && w < 60) kind = REQ_REPLY;
        else if (lock_q == LS_SETTING && pend_cnt == '0 && w < 50) kind = REQ_ACQUIRE;
        else if (lock_q == LS_LOCAL && w < 35) kind = REQ_RELEASE;
        else if (lock_q == LS_REMOTE && w < 35) begin
          kind = (w < 25) ? REQ_REMOTE_UNLOCK : REQ_HOST_DIED;
          send_event(kind, (w < 30) ? holder_q : pick_id());
          continue;
        end
        else if (lock_q == LS_RECOVER && w < 35) kind = REQ_SETTLE;
        else if (lock_q == LS_NONE && w < 30) kind = REQ_ACQUIRE;
        else kind = 3'($urandom_range(0, 7));
        send_event(kind, pick_id());
      end
    end
    drain();
  endtask

  // Compare each strobed result with the oldest expectation.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else if (!rst && done) begin
      if (outcome_q.size() == 0) begin
        mismatch_cnt <= mismatch_cnt + 1;
        if (mismatch_cnt < 10) $display("unexpected result %h", result);
      end else begin
        due_outcome = outcome_q.pop_front();
        if (result.status          !== due_outcome.status          ||
            result.reply_code      !== due_outcome.reply_code      ||
            result.send_want_lock  !== due_outcome.send_want_lock  ||
            result.send_unlock     !== due_outcome.send_unlock     ||
            result.reply_underflow !== due_outcome.reply_underflow ||
            result.lock_state_out  !== due_outcome.lock_state_out  ||
            result.holder_id_out   !== due_outcome.holder_id_out) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < 10)
            $display("mismatch: exp st=%0d rc=%0d want=%b unl=%b und=%b ls=%0d hold=%h",
                     due_outcome.status, due_outcome.reply_code,
                     due_outcome.send_want_lock, due_outcome.send_unlock,
                     due_outcome.reply_underflow, due_outcome.lock_state_out,
                     due_outcome.holder_id_out);
          if (mismatch_cnt < 10)
            $display("          got st=%0d rc=%0d want=%b unl=%b und=%b ls=%0d hold=%h",
                     result.status, result.reply_code, result.send_want_lock,
                     result.send_unlock, result.reply_underflow,
                     result.lock_state_out, result.holder_id_out);
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    mismatch_cnt = 0;
    cycle_cnt = 0;
    gaps_on = 1'b1;
    lock_q = LS_NONE;
    pend_cnt = '0;
    holder_q = '0;
    host_id_q = '0;
    peer_cnt_q = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_negotiation_off();
    test_protocol_walk();
    test_random_traffic();
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0 && outcome_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
